// ===== rtl/sgd_mf_pkg.sv =====
// Shared types, constants and helpers for the SGD matrix factorization block.
`timescale 1ns / 1ps
package sgd_mf_pkg;

    localparam int FACTORS_DEF   = 100;
    localparam int USER_ROWS_DEF = 256;
    localparam int ITEM_COLS_DEF = 256;

    localparam logic [31:0] LEARN_RATE_RST = 32'd858993;
    localparam logic [31:0] DECAY_RATE_RST = 32'd8590;
    localparam logic [63:0] THRESHOLD_RST  = 64'd0;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LEARN_RATE = 2'd0,
        REG_DECAY_RATE = 2'd1,
        REG_THRESHOLD  = 2'd2
    } reg_idx_t;

    // Request commands
    typedef enum logic [2:0] {
        CMD_WR_USER = 3'd0,
        CMD_WR_ITEM = 3'd1,
        CMD_RD_USER = 3'd2,
        CMD_RD_ITEM = 3'd3,
        CMD_TRAIN   = 3'd4,
        CMD_EPOCH   = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [6:0]         factor_index;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic signed [31:0] item_error;
        logic [63:0]        epoch_error;
        logic               converged;
        logic [15:0]        epoch_count;
    } out_t;

    typedef struct packed {
        logic [31:0] learn_rate;
        logic [31:0] decay_rate;
        logic [63:0] error_threshold;
    } cfg_t;

    // Clamp a wide signed value to the Q8.24 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/sgd_matrix_factorization_top.sv =====
// Top level of the SGD matrix factorization trainer.
`timescale 1ns / 1ps
// Trains user and item factor tables (signed Q8.24, held in two RAMs with a
// registered read) by stochastic gradient descent, one request at a time. Factor
// writes, end-of-epoch and unused commands go straight to the result state;
// factor reads first pass through the read state. A train request runs a dot
// product through the shared multiplier, then the error and its square, then
// the user and item updates for each factor, each one a chain of three
// products on the same multiplier, and then hands the result over. The next
// request can be taken in the cycle after the result is handed over. A result
// waits in an output register so the next request can be taken while it is
// held. Factor entries read before they are written return undefined data.
module sgd_matrix_factorization_top #(
    parameter int FACTORS   = sgd_mf_pkg::FACTORS_DEF,
    parameter int USER_ROWS = sgd_mf_pkg::USER_ROWS_DEF,
    parameter int ITEM_COLS = sgd_mf_pkg::ITEM_COLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  sgd_mf_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sgd_mf_pkg::out_t m_data
);
    import sgd_mf_pkg::*;

    cfg_t cfg_reg;
    logic res_valid, res_ready;
    out_t res_data;
    logic m_valid_reg;
    out_t m_data_reg;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_rate      <= LEARN_RATE_RST;
            cfg_reg.decay_rate      <= DECAY_RATE_RST;
            cfg_reg.error_threshold <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEARN_RATE: cfg_reg.learn_rate      <= cfg_wr_data[31:0];
                REG_DECAY_RATE: cfg_reg.decay_rate      <= cfg_wr_data[31:0];
                REG_THRESHOLD:  cfg_reg.error_threshold <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    sgd_mf_core #(
        .FACTORS   (FACTORS),
        .USER_ROWS (USER_ROWS),
        .ITEM_COLS (ITEM_COLS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Output register: load a finished result whenever it is free or being read out
    assign res_ready = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/sgd_mf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sgd_mf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; read data is registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sgd_mf_core.sv =====
// Command sequencer, factor memories and shared multiplier of the SGD trainer.
`timescale 1ns / 1ps
module sgd_mf_core #(
    parameter int FACTORS   = sgd_mf_pkg::FACTORS_DEF,
    parameter int USER_ROWS = sgd_mf_pkg::USER_ROWS_DEF,
    parameter int ITEM_COLS = sgd_mf_pkg::ITEM_COLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sgd_mf_pkg::cfg_t cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  sgd_mf_pkg::in_t  in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output sgd_mf_pkg::out_t res_data
);
    import sgd_mf_pkg::*;

    localparam int U_DEPTH = USER_ROWS * FACTORS;
    localparam int I_DEPTH = ITEM_COLS * FACTORS;
    localparam int U_AW    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
    localparam int I_AW    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
    localparam int K_W     = $clog2(FACTORS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_DOT, ST_ERR, ST_SQ, ST_SUM,
        ST_U1, ST_U2, ST_U3, ST_U4, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_DONE
    } state_t;

    state_t             state_reg;
    logic               is_user_reg, hit_reg;
    logic signed [31:0] v_reg;
    logic [U_AW-1:0]    ub_reg;
    logic [I_AW-1:0]    ib_reg;
    logic [K_W-1:0]     k_reg;
    logic               d1_reg, d2_reg;
    logic signed [63:0] acc_reg, prod_reg, step_reg;
    logic signed [31:0] err_reg, u_reg, q_reg, unew_reg;
    logic [63:0]        sum_reg;
    logic [15:0]        cnt_reg;
    logic signed [31:0] rd_out_reg, err_out_reg;
    logic [63:0]        esum_out_reg;
    logic               conv_out_reg;

    logic               accept, row_ok, col_ok, fi_ok, issue;
    logic [U_AW-1:0]    u_base_in, u_addr_in, u_raddr, u_waddr;
    logic [I_AW-1:0]    i_base_in, i_addr_in, i_raddr, i_waddr;
    logic [K_W-1:0]     rd_k;
    logic               u_we, i_we;
    logic signed [31:0] u_wdata, i_wdata, u_rd, q_rd;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [63:0] prod_next;
    logic signed [31:0] g_cur, fac_base, fac_new, err_next;
    logic [64:0]        sum_add;
    logic [63:0]        sum_next;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign row_ok = int'(in_data.row) < USER_ROWS;
    assign col_ok = int'(in_data.col) < ITEM_COLS;
    assign fi_ok  = int'(in_data.factor_index) < FACTORS;
    assign issue  = (k_reg != K_W'(FACTORS));

    assign u_base_in = U_AW'(int'(in_data.row) * FACTORS);
    assign i_base_in = I_AW'(int'(in_data.col) * FACTORS);
    assign u_addr_in = U_AW'(int'(in_data.row) * FACTORS + int'(in_data.factor_index));
    assign i_addr_in = I_AW'(int'(in_data.col) * FACTORS + int'(in_data.factor_index));

    // Read address: request fields when idle, otherwise the factor walk
    assign rd_k    = (state_reg == ST_Q4) ? k_reg + K_W'(1) : k_reg;
    assign u_raddr = (state_reg == ST_IDLE) ? u_addr_in : ub_reg + U_AW'(rd_k);
    assign i_raddr = (state_reg == ST_IDLE) ? i_addr_in : ib_reg + I_AW'(rd_k);

    // Write ports: loads from requests, updates from the training pass
    always_comb begin
        u_we    = 1'b0;
        u_waddr = ub_reg + U_AW'(k_reg);
        u_wdata = fac_new;
        i_we    = 1'b0;
        i_waddr = ib_reg + I_AW'(k_reg);
        i_wdata = fac_new;
        if (state_reg == ST_IDLE) begin
            u_waddr = u_addr_in;
            u_wdata = in_data.value;
            i_waddr = i_addr_in;
            i_wdata = in_data.value;
            u_we    = accept && (in_data.command == CMD_WR_USER) && row_ok && fi_ok;
            i_we    = accept && (in_data.command == CMD_WR_ITEM) && col_ok && fi_ok;
        end else if (state_reg == ST_U4) begin
            u_we = 1'b1;
        end else if (state_reg == ST_Q4) begin
            i_we = 1'b1;
        end
    end

    sgd_mf_ram #(.WIDTH(32), .DEPTH(U_DEPTH)) u_user_ram (
        .aclk  (aclk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rd)
    );

    sgd_mf_ram #(.WIDTH(32), .DEPTH(I_DEPTH)) u_item_ram (
        .aclk  (aclk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (i_raddr),
        .rdata (q_rd)
    );

    // Shared multiplier: pick operands by step
    assign g_cur = sat32(prod_reg >>> 24);
    always_comb begin
        unique case (state_reg)
            ST_SQ: begin
                mul_a = 33'(err_reg);
                mul_b = 33'(err_reg);
            end
            ST_U1: begin
                mul_a = 33'(err_reg);
                mul_b = 33'(q_rd);
            end
            ST_U2, ST_Q2: begin
                mul_a = 33'(g_cur);
                mul_b = $signed({1'b0, cfg.learn_rate});
            end
            ST_U3: begin
                mul_a = 33'(u_reg);
                mul_b = $signed({1'b0, cfg.decay_rate});
            end
            ST_Q1: begin
                mul_a = 33'(err_reg);
                mul_b = 33'(unew_reg);
            end
            ST_Q3: begin
                mul_a = 33'(q_reg);
                mul_b = $signed({1'b0, cfg.decay_rate});
            end
            default: begin
                mul_a = 33'(u_rd);
                mul_b = 33'(q_rd);
            end
        endcase
    end
    assign mul_full  = mul_a * mul_b;
    assign prod_next = mul_full[63:0];

    // Factor update: f + step - decay, decay product sits in prod_reg
    assign fac_base = (state_reg == ST_Q4) ? q_reg : u_reg;
    assign fac_new  = sat32(64'(fac_base) + step_reg - (prod_reg >>> 32));

    assign err_next = sat32(64'(v_reg) - acc_reg);
    assign sum_add  = {1'b0, sum_reg} + {25'd0, prod_reg[63:24]};
    assign sum_next = sum_add[64] ? '1 : sum_add[63:0];

    // Sequencer
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            d1_reg    <= 1'b0;
            d2_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        v_reg        <= in_data.value;
                        ub_reg       <= u_base_in;
                        ib_reg       <= i_base_in;
                        k_reg        <= '0;
                        d1_reg       <= 1'b0;
                        d2_reg       <= 1'b0;
                        acc_reg      <= '0;
                        rd_out_reg   <= '0;
                        err_out_reg  <= '0;
                        conv_out_reg <= 1'b0;
                        esum_out_reg <= sum_reg;
                        unique case (in_data.command)
                            CMD_RD_USER: begin
                                hit_reg     <= row_ok && fi_ok;
                                is_user_reg <= 1'b1;
                                state_reg   <= ST_READ;
                            end
                            CMD_RD_ITEM: begin
                                hit_reg     <= col_ok && fi_ok;
                                is_user_reg <= 1'b0;
                                state_reg   <= ST_READ;
                            end
                            CMD_TRAIN: begin
                                state_reg <= (row_ok && col_ok) ? ST_DOT : ST_DONE;
                            end
                            CMD_EPOCH: begin
                                conv_out_reg <= sum_reg < cfg.error_threshold;
                                cnt_reg      <= cnt_reg + 16'd1;
                                sum_reg      <= '0;
                                state_reg    <= ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    rd_out_reg <= hit_reg ? (is_user_reg ? u_rd : q_rd) : 32'sd0;
                    state_reg  <= ST_DONE;
                end
                ST_DOT: begin
                    // Issue one factor pair a cycle, multiply, then accumulate
                    if (issue) begin
                        k_reg <= k_reg + K_W'(1);
                    end
                    d1_reg <= issue;
                    d2_reg <= d1_reg;
                    if (d2_reg) begin
                        acc_reg <= acc_reg + (prod_reg >>> 24);
                    end
                    if (!issue && !d1_reg && !d2_reg) begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= err_next;
                    k_reg     <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sum_reg   <= sum_next;
                    state_reg <= ST_U1;
                end
                ST_U1: begin
                    u_reg     <= u_rd;
                    q_reg     <= q_rd;
                    state_reg <= ST_U2;
                end
                ST_U2: begin
                    state_reg <= ST_U3;
                end
                ST_U3: begin
                    step_reg  <= prod_reg >>> 31;
                    state_reg <= ST_U4;
                end
                ST_U4: begin
                    unew_reg  <= fac_new;
                    state_reg <= ST_Q1;
                end
                ST_Q1: begin
                    state_reg <= ST_Q2;
                end
                ST_Q2: begin
                    state_reg <= ST_Q3;
                end
                ST_Q3: begin
                    step_reg  <= prod_reg >>> 31;
                    state_reg <= ST_Q4;
                end
                ST_Q4: begin
                    if (k_reg == K_W'(FACTORS - 1)) begin
                        err_out_reg  <= err_reg;
                        esum_out_reg <= sum_reg;
                        state_reg    <= ST_DONE;
                    end else begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= ST_U1;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res_data.read_value  = rd_out_reg;
        res_data.item_error  = err_out_reg;
        res_data.epoch_error = esum_out_reg;
        res_data.converged   = conv_out_reg;
        res_data.epoch_count = cnt_reg;
    end

endmodule

// ===== rtl/sgd_mf_chk.sv =====
// Port-level checks for the SGD matrix factorization top level.
`timescale 1ns / 1ps
module sgd_mf_chk (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input sgd_mf_pkg::in_t  s_data,
    input logic             m_valid,
    input logic             m_ready,
    input sgd_mf_pkg::out_t m_data
);

    // Waiting request holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // Stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Convergence is only reported by end of epoch, which reads nothing
    a_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.converged |-> m_data.read_value == 32'sd0
            && m_data.item_error == 32'sd0)
        else $error("converged flag on a non-epoch result");

    // A read result never carries a training error
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_value != 32'sd0 |-> m_data.item_error == 32'sd0)
        else $error("read and train fields both set");

endmodule

bind sgd_matrix_factorization_top sgd_mf_chk u_sgd_mf_chk (.*);
